>>> design/mqf_pkg.sv
// Shared types and constants for the multi-queue message FIFO.
// No dependencies; every other file of the block depends on this package.
package mqf_pkg;

  // Width of the message and address fields on the channels.
  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2
  } mqf_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mqf_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_RD,
    S_FIN
  } mqf_state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic capture;    // latch request, read pointer pair
    logic update;     // pointer/store update, issue store read
    logic res_ptr;    // build result from pointer state
    logic res_store;  // take popped entry into result
    logic load_out;   // move result into output register
  } mqf_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic pop_ok;
  } mqf_stat_t;

endpackage

>>> design/mqf_if.sv
// Request and response channel interfaces of the multi-queue message FIFO.
// Depends on mqf_pkg for the field width.
interface mqf_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [2:0]                    queue_index;
  logic [mqf_pkg::FIELD_W-1:0]   msg_value;
  logic [mqf_pkg::FIELD_W-1:0]   msg_address;

  modport source (output valid, kind, queue_index, msg_value, msg_address, input ready);
  modport sink   (input valid, kind, queue_index, msg_value, msg_address, output ready);
endinterface

interface mqf_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [mqf_pkg::FIELD_W-1:0]   out_value;
  logic [mqf_pkg::FIELD_W-1:0]   out_address;
  logic                          not_empty;

  modport source (output valid, status, out_value, out_address, not_empty, input ready);
  modport sink   (input valid, status, out_value, out_address, not_empty, output ready);
endinterface

>>> design/mqf_ctrl.sv
// Sequencing state machine of the multi-queue message FIFO.
// Depends on mqf_pkg for state, command and status types.
module mqf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               resp_valid,
  input  logic               resp_ready,
  input  mqf_pkg::mqf_stat_t stat,
  output mqf_pkg::mqf_cmd_t  cmd
);
  import mqf_pkg::*;

  mqf_state_t state, state_next;
  logic       out_vld;
  logic       out_free;

  assign out_free   = !out_vld || resp_ready;
  assign resp_valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_PTR;
      end
      S_PTR: begin
        state_next = stat.pop_ok ? S_RD : S_FIN;
      end
      S_RD: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_PTR: begin
        cmd.update  = 1'b1;
        cmd.res_ptr = 1'b1;
      end
      S_RD: begin
        cmd.res_store = 1'b1;
      end
      S_FIN: begin
        cmd.load_out = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld <= 1'b1;
    end else if (resp_ready) begin
      out_vld <= 1'b0;
    end
  end

endmodule

>>> design/mqf_dp.sv
// Datapath of the multi-queue message FIFO: pointer memory, message store,
// result and output registers. Depends on mqf_pkg.
module mqf_dp #(
  parameter int NUM_QUEUES    = 8,
  parameter int RING_DEPTH    = 16,
  parameter int VALUE_WIDTH   = 32,
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mqf_pkg::mqf_cmd_t             cmd,
  output mqf_pkg::mqf_stat_t            stat,
  input  logic [1:0]                    kind,
  input  logic [2:0]                    queue_index,
  input  logic [mqf_pkg::FIELD_W-1:0]   msg_value,
  input  logic [mqf_pkg::FIELD_W-1:0]   msg_address,
  output logic [1:0]                    status,
  output logic [mqf_pkg::FIELD_W-1:0]   out_value,
  output logic [mqf_pkg::FIELD_W-1:0]   out_address,
  output logic                          not_empty
);
  import mqf_pkg::*;

  localparam int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int ENTRY_W     = VALUE_WIDTH + ADDRESS_WIDTH;
  localparam int STORE_DEPTH = NUM_QUEUES << PTR_W;

  // Queue index wraps modulo NUM_QUEUES; index is only 3 bits wide.
  function automatic logic [QW-1:0] qwrap(input logic [2:0] idx);
    logic [2:0] v;
    v = idx;
    for (int i = 0; i < 8; i++) begin
      if ({29'd0, v} >= 32'(NUM_QUEUES)) v = v - 3'(NUM_QUEUES);
    end
    return QW'(v);
  endfunction

  logic [1:0]               kind_r;
  logic [QW-1:0]            q_r;
  logic [VALUE_WIDTH-1:0]   val_r;
  logic [ADDRESS_WIDTH-1:0] adr_r;

  logic [2*PTR_W-1:0]       ptr_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]    ptr_vld;
  logic [2*PTR_W-1:0]       ptr_rd;
  logic                     ptr_rd_vld;

  logic [ENTRY_W-1:0]       store [STORE_DEPTH];
  logic [ENTRY_W-1:0]       store_rd;

  logic [PTR_W-1:0] head, tail, head_inc, tail_inc, head_nx, tail_nx;
  logic             is_push, is_pop, full, empty, push_ok, pop_ok;

  logic [1:0]               res_status;
  logic                     res_ne;
  logic [FIELD_W-1:0]       res_val, res_adr;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      q_r    <= qwrap(queue_index);
      val_r  <= msg_value[VALUE_WIDTH-1:0];
      adr_r  <= msg_address[ADDRESS_WIDTH-1:0];
    end
  end

  // Pointer pair memory, {head, tail} per queue, registered read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptr_rd <= ptr_mem[qwrap(queue_index)];
    end
    if (cmd.update && (push_ok || pop_ok)) begin
      ptr_mem[q_r] <= {head_nx, tail_nx};
    end
  end

  // Entries never written read as zero pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_vld <= '0;
    end else if (cmd.update && (push_ok || pop_ok)) begin
      ptr_vld[q_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptr_rd_vld <= ptr_vld[qwrap(queue_index)];
    end
  end

  assign head = ptr_rd_vld ? ptr_rd[2*PTR_W-1:PTR_W] : '0;
  assign tail = ptr_rd_vld ? ptr_rd[PTR_W-1:0]       : '0;

  assign head_inc = (head == PTR_W'(RING_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc = (tail == PTR_W'(RING_DEPTH - 1)) ? '0 : tail + PTR_W'(1);

  assign is_push = (kind_r == KIND_PUSH);
  assign is_pop  = (kind_r == KIND_POP);
  assign full    = (head_inc == tail);
  assign empty   = (head == tail);
  assign push_ok = is_push && !full;
  assign pop_ok  = is_pop && !empty;
  assign head_nx = push_ok ? head_inc : head;
  assign tail_nx = pop_ok  ? tail_inc : tail;

  assign stat.pop_ok  = pop_ok;

  // Message store, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.update && push_ok) begin
      store[{q_r, head}] <= {val_r, adr_r};
    end
    if (cmd.update && pop_ok) begin
      store_rd <= store[{q_r, tail}];
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_ptr) begin
      if (is_push && full) begin
        res_status <= ST_FULL;
      end else if (is_pop && empty) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
      res_ne  <= (head_nx != tail_nx);
      res_val <= '1;
      res_adr <= '1;
    end else if (cmd.res_store) begin
      res_val <= FIELD_W'(store_rd[ENTRY_W-1:ADDRESS_WIDTH]);
      res_adr <= FIELD_W'(store_rd[ADDRESS_WIDTH-1:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      out_value   <= res_val;
      out_address <= res_adr;
      not_empty   <= res_ne;
    end
  end

endmodule

>>> design/multi_queue_message_fifo.sv
// Multi-queue message FIFO: NUM_QUEUES circular message queues over one
// shared message store. Depends on mqf_pkg, mqf_if, mqf_ctrl and mqf_dp.
//
// Each request pushes a (value, address) message onto a queue, pops the
// oldest message from a queue, or asks whether a queue holds anything, and
// gives exactly one response. A queue holds at most RING_DEPTH-1 messages;
// a push onto a full queue is refused with status full, a pop from an empty
// queue returns status empty. out_value and out_address are all ones except
// on a successful pop, and not_empty reports the addressed queue after the
// operation. A queue index at or above NUM_QUEUES wraps modulo NUM_QUEUES;
// the unused kind code acts as a query. Requests are handled one at a time:
// the response reaches the output register after the registered read of the
// per-queue pointer memory and, for a successful pop, after the registered
// read of the message store as well. The next request is accepted as soon as
// the previous response is in the output register, even if it has not yet
// been taken. While an untaken response holds the output register, the
// following request waits with its result ready and no further request is
// accepted. No clearing pass is needed after reset: per-queue valid bits
// make untouched queues read as empty.
module multi_queue_message_fifo #(
  parameter int NUM_QUEUES    = 8,
  parameter int RING_DEPTH    = 16,
  parameter int VALUE_WIDTH   = 32,
  parameter int ADDRESS_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  mqf_in_if.sink   req,
  mqf_out_if.source resp
);
  import mqf_pkg::*;

  mqf_cmd_t  cmd;   // sequencing commands to the datapath
  mqf_stat_t stat;  // pop outcome back to the controller

  mqf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mqf_dp #(
    .NUM_QUEUES    (NUM_QUEUES),
    .RING_DEPTH    (RING_DEPTH),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (req.kind),
    .queue_index (req.queue_index),
    .msg_value   (req.msg_value),
    .msg_address (req.msg_address),
    .status      (resp.status),
    .out_value   (resp.out_value),
    .out_address (resp.out_address),
    .not_empty   (resp.not_empty)
  );

  // One request in flight: acceptance closes the request side next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // A refused push only happens on a queue that holds messages.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (resp.valid && resp.status == ST_FULL) |-> resp.not_empty)
    else $error("full status on an empty queue");

  // A pop from an empty queue leaves it empty.
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (resp.valid && resp.status == ST_EMPTY) |-> !resp.not_empty)
    else $error("empty status with not_empty set");

  // Failed operations return all ones in both words.
  a_fail_ones: assert property (@(posedge clk) disable iff (rst)
    (resp.valid && resp.status != ST_OK) |->
      (resp.out_value == '1 && resp.out_address == '1))
    else $error("failed operation returned data");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for multi_queue_message_fifo: directed, backpressure and random
// request traffic, with every response checked against an in-bench queue predictor.
// Depends on mqf_pkg and mqf_if from the design.
module tb;
  import mqf_pkg::*;

  localparam int Q_COUNT = 8;
  localparam int RING = 16;
  localparam int VW = 32;
  localparam int AW = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Unused kind code; the block treats it as a query.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [31:0] ALL_ONES = '1;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [31:0] address;
    logic        not_empty;
  } resp_t;

  logic clk;
  logic rst;

  mqf_in_if  req_if();
  mqf_out_if resp_if();

  multi_queue_message_fifo #(
    .NUM_QUEUES   (Q_COUNT),
    .RING_DEPTH   (RING),
    .VALUE_WIDTH  (VW),
    .ADDRESS_WIDTH(AW)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .resp(resp_if)
  );

  // Predictor state: per-queue pointers and the shared message store.
  logic [3:0]  q_head [Q_COUNT];
  logic [3:0]  q_tail [Q_COUNT];
  logic [31:0] store_value   [Q_COUNT*RING];
  logic [31:0] store_address [Q_COUNT*RING];

  // Responses owed by the block, oldest first.
  resp_t pending_resp[$];

  int err_count;
  int resp_checked;
  int n_push, n_push_full, n_pop, n_pop_empty, n_query;
  int cycle_cnt;

  // Traffic shaping knobs, set by the test tasks.
  bit req_no_idle;
  bit resp_no_idle;
  int resp_hold_left;   // long receiver hold-off, counted down by the responder
  int resp_gap_left;

  // Clock: period 10.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog: a correct run finishes far below this.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TIMEOUT after %0d cycles, %0d responses still owed", cycle_cnt,
             pending_resp.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Work out the response to one accepted request and advance the queue state.
  function automatic resp_t predict_queue_op(logic [1:0] kind, logic [2:0] qi,
                                             logic [31:0] val, logic [31:0] adr);
    resp_t r;
    int q;
    logic [3:0] h, t, nh;
    int base;
    q = int'(qi) % Q_COUNT;
    h = q_head[q];
    t = q_tail[q];
    base = q * RING;
    r.status = ST_OK;
    r.value = ALL_ONES;
    r.address = ALL_ONES;
    if (kind == KIND_PUSH) begin
      n_push++;
      nh = 4'((int'(h) + 1) % RING);
      if (nh != t) begin
        store_value[base + h] = val;
        store_address[base + h] = adr;
        h = nh;
      end else begin
        r.status = ST_FULL;
        n_push_full++;
      end
    end else if (kind == KIND_POP) begin
      n_pop++;
      if (h != t) begin
        r.value = store_value[base + t];
        r.address = store_address[base + t];
        t = 4'((int'(t) + 1) % RING);
      end else begin
        r.status = ST_EMPTY;
        n_pop_empty++;
      end
    end else begin
      // Query, and the spare code behaves the same way.
      n_query++;
    end
    q_head[q] = h;
    q_tail[q] = t;
    r.not_empty = (h != t);
    return r;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Data words: mostly random, with the two extremes mixed in.
  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return $urandom();
  endfunction

  // Offer one request, hold it until accepted, then log its expected response.
  // Inputs change on the falling edge; acceptance is seen on the rising edge.
  task automatic send_req(logic [1:0] kind, logic [2:0] qi, logic [31:0] val,
                          logic [31:0] adr);
    int n;
    n = 0;
    if (!req_no_idle && $urandom_range(0, 2) == 0) n = pick_idle();
    if (n > 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.kind = kind;
    req_if.queue_index = qi;
    req_if.msg_value = val;
    req_if.msg_address = adr;
    do @(posedge clk); while (!req_if.ready);
    pending_resp.push_back(predict_queue_op(kind, qi, val, adr));
  endtask

  // Receiver: random ready with short and long gaps, plus an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      resp_if.ready = 1'b0;
    end else if (resp_hold_left > 0) begin
      resp_if.ready = 1'b0;
      resp_hold_left--;
    end else if (resp_gap_left > 0) begin
      resp_if.ready = 1'b0;
      resp_gap_left--;
    end else begin
      resp_if.ready = 1'b1;
      if (!resp_no_idle && $urandom_range(0, 3) == 0) resp_gap_left = pick_idle();
    end
  end

  // Response checker: every accepted response against the oldest expectation.
  always @(posedge clk) begin
    resp_t want;
    if (!rst && resp_if.valid && resp_if.ready) begin
      if (pending_resp.size() == 0) begin
        report_error("response with no request outstanding");
      end else begin
        want = pending_resp.pop_front();
        resp_checked++;
        if (resp_if.status !== want.status)
          report_error($sformatf("resp %0d status %0d, expected %0d", resp_checked,
                                 resp_if.status, want.status));
        if (resp_if.out_value !== want.value)
          report_error($sformatf("resp %0d out_value %h, expected %h", resp_checked,
                                 resp_if.out_value, want.value));
        if (resp_if.out_address !== want.address)
          report_error($sformatf("resp %0d out_address %h, expected %h", resp_checked,
                                 resp_if.out_address, want.address));
        if (resp_if.not_empty !== want.not_empty)
          report_error($sformatf("resp %0d not_empty %b, expected %b", resp_checked,
                                 resp_if.not_empty, want.not_empty));
      end
    end
  end

  // Empty-queue behavior: query, pop and the spare kind code on untouched queues.
  task automatic test_empty_queues();
    send_req(KIND_QUERY, 3'd0, '0, '0);
    send_req(KIND_POP, 3'd0, ALL_ONES, ALL_ONES);
    send_req(KIND_SPARE, 3'd0, rand_word(), rand_word());
    send_req(KIND_QUERY, 3'd7, ALL_ONES, ALL_ONES);
  endtask

  // Field extremes through push and pop, with a third pop on queue 0 that hits empty.
  task automatic test_field_extremes();
    send_req(KIND_PUSH, 3'd0, '0, '0);
    send_req(KIND_PUSH, 3'd0, ALL_ONES, ALL_ONES);
    send_req(KIND_PUSH, 3'd7, 32'hAAAA_5555, 32'h5555_AAAA);
    send_req(KIND_POP, 3'd0, rand_word(), rand_word());
    send_req(KIND_POP, 3'd0, rand_word(), rand_word());
    send_req(KIND_POP, 3'd0, rand_word(), rand_word());
    send_req(KIND_POP, 3'd7, '0, '0);
  endtask

  // Fill one queue to its RING-1 capacity, get a push refused, then take one out.
  task automatic test_full_queue();
    for (int i = 0; i < RING - 1; i++) send_req(KIND_PUSH, 3'd5, rand_word(), rand_word());
    send_req(KIND_PUSH, 3'd5, ALL_ONES, ALL_ONES);
    send_req(KIND_POP, 3'd5, '0, '0);
  endtask

  // Receiver holds off for a long stretch while requests keep coming back to back,
  // so the output register fills and the block stalls its request side.
  task automatic test_backpressure();
    req_no_idle = 1'b1;
    resp_hold_left = 250;
    for (int i = 0; i < 40; i++)
      send_req((i % 3 == 2) ? KIND_POP : KIND_PUSH, 3'(i % 4), rand_word(), rand_word());
    req_no_idle = 1'b0;
  endtask

  // Random traffic in bursts. Each burst favors one hot queue and leans toward
  // pushes, pops or neither, so queues are driven both to full and to empty.
  task automatic test_random_traffic(int bursts);
    int hot, push_pct, r;
    logic [1:0] kind;
    logic [2:0] qi;
    for (int b = 0; b < bursts; b++) begin
      hot = $urandom_range(0, Q_COUNT - 1);
      case ($urandom_range(0, 2))
        0: push_pct = 75;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      // Some bursts run with no idling on one or both sides.
      req_no_idle = ($urandom_range(0, 4) == 0);
      resp_no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 50; i++) begin
        qi = ($urandom_range(0, 3) != 0) ? 3'(hot) : 3'($urandom_range(0, Q_COUNT - 1));
        r = $urandom_range(0, 99);
        if (r < 4) kind = KIND_QUERY;
        else if (r < 8) kind = KIND_SPARE;
        else kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
        send_req(kind, qi, rand_word(), rand_word());
      end
    end
    req_no_idle = 1'b0;
    resp_no_idle = 1'b0;
  endtask

  initial begin
    err_count = 0;
    resp_checked = 0;
    n_push = 0;
    n_push_full = 0;
    n_pop = 0;
    n_pop_empty = 0;
    n_query = 0;
    req_no_idle = 1'b0;
    resp_no_idle = 1'b0;
    resp_hold_left = 0;
    resp_gap_left = 0;
    for (int q = 0; q < Q_COUNT; q++) begin
      q_head[q] = '0;
      q_tail[q] = '0;
    end
    // All block inputs known from time zero.
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.kind = KIND_PUSH;
    req_if.queue_index = '0;
    req_if.msg_value = '0;
    req_if.msg_address = '0;
    resp_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queues();
    test_field_extremes();
    test_full_queue();
    test_backpressure();
    test_random_traffic(36);

    // Drop valid, drain outstanding responses, then allow a short settle window
    // in which any extra response would be flagged by the checker.
    @(negedge clk);
    req_if.valid = 1'b0;
    wait (pending_resp.size() == 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d pushes (%0d refused full), %0d pops (%0d empty), %0d queries",
             n_push + n_pop + n_query, n_push, n_push_full, n_pop, n_pop_empty, n_query);
    $display("Checked %0d responses with %0d errors", resp_checked, err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
